FILE: design/oaids_pkg.sv
// Shared types and codes for the ordered array block.
// No dependencies; imported by the cell, the controller and the top level.
package oaids_pkg;

   localparam logic [1:0] ACT_INSERT       = 2'd0;
   localparam logic [1:0] ACT_DELETE_AT    = 2'd1;
   localparam logic [1:0] ACT_DELETE_VALUE = 2'd2;
   localparam logic [1:0] ACT_SEARCH       = 2'd3;

   localparam logic [1:0] STAT_DONE  = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        keep;
      logic [31:0] value;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROT,
      ST_DONE
   } oaids_state_type;

endpackage

FILE: design/oaids_cell.sv
// One array slot of the cell chain: holds a word and takes its neighbor's word on shifts.
// Depends on oaids_pkg.
module oaids_cell
   import oaids_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int IDX   = 0,
   localparam int LW   = $clog2(DEPTH + 1)
) (
   input  logic               clock,
   input  cell_cmd_type       cmd,
   input  logic [LW-1:0]      pos,
   input  logic [LW-1:0]      len,
   input  logic [31:0]        head,
   input  logic [31:0]        left_data,
   input  logic [31:0]        right_data,
   output logic [31:0]        data
);

   localparam logic [LW-1:0] IDX_V  = LW'(IDX);
   localparam logic [LW-1:0] IDX_P1 = LW'(IDX + 1);

   logic [31:0] data_ff;
   logic [31:0] data_in;

   always_comb begin
      data_in = data_ff;
      unique case (cmd.op)
         CELL_INSERT: begin
            if (IDX_V == pos) begin
               data_in = cmd.value;
            end else if (IDX_V > pos && IDX_V <= len) begin
               data_in = left_data;
            end
         end
         CELL_DELETE: begin
            if (IDX_V >= pos && IDX_P1 < len) begin
               data_in = right_data;
            end
         end
         CELL_ROTATE: begin
            if (cmd.keep && IDX_P1 == len) begin
               data_in = head;
            end else begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

FILE: design/oaids_ctrl.sv
// Request sequencer: range checks, length, rotation counter and result registers.
// Depends on oaids_pkg; drives the command broadcast to every oaids_cell.
module oaids_ctrl
   import oaids_pkg::*;
#(
   parameter int DEPTH = 1024,
   localparam int LW   = $clog2(DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_action,
   input  logic [10:0]         req_position,
   input  logic signed [31:0]  req_item_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_found,
   output logic [10:0]         rsp_removed_count,
   output logic [10:0]         rsp_length_now,
   output logic [1:0]          rsp_status,
   input  logic [31:0]         head,
   output cell_cmd_type        cmd,
   output logic [LW-1:0]       cell_pos,
   output logic [LW-1:0]       cell_len
);

   localparam int CW = (LW > 11) ? LW : 11;

   oaids_state_type state_ff, state_in;

   logic [LW-1:0] length_ff, length_in;
   logic [LW-1:0] cnt_ff, cnt_in;
   logic [31:0]   val_ff, val_in;
   logic          del_ff, del_in;
   logic          res_found_ff, res_found_in;
   logic [LW-1:0] res_removed_ff, res_removed_in;
   logic [1:0]    res_status_ff, res_status_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_found_ff, rsp_found_in;
   logic [10:0]   rsp_removed_ff, rsp_removed_in;
   logic [10:0]   rsp_length_ff, rsp_length_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;

   logic          req_fire;
   logic          out_free;
   logic          ins_range, del_range, full, rot_start;
   logic          match, drop;
   logic [CW-1:0] pos_w, len_w, removed_w;

   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pos_w     = CW'(req_position);
   assign len_w     = CW'(length_ff);
   assign removed_w = CW'(res_removed_ff);
   assign ins_range = pos_w > len_w;
   assign del_range = pos_w >= len_w;
   assign full      = length_ff == LW'(DEPTH);
   assign rot_start = (req_action == ACT_DELETE_VALUE || req_action == ACT_SEARCH)
                      && length_ff != '0;
   assign match     = head == val_ff;
   assign drop      = del_ff && match;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = rot_start ? ST_ROT : ST_DONE;
            end
         end
         ST_ROT: begin
            if (cnt_ff == LW'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      cmd.op         = CELL_HOLD;
      cmd.keep       = 1'b1;
      cmd.value      = req_item_value;
      cell_pos       = LW'(req_position);
      cell_len       = length_ff;
      length_in      = length_ff;
      cnt_in         = cnt_ff;
      val_in         = val_ff;
      del_in         = del_ff;
      res_found_in   = res_found_ff;
      res_removed_in = res_removed_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_found_in   = rsp_found_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_length_in  = rsp_length_ff;
      rsp_status_in  = rsp_status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               res_found_in   = 1'b0;
               res_removed_in = '0;
               res_status_in  = STAT_DONE;
               val_in         = req_item_value;
               del_in         = req_action == ACT_DELETE_VALUE;
               cnt_in         = length_ff;
               case (req_action)
                  ACT_INSERT: begin
                     if (ins_range) begin
                        res_status_in = STAT_RANGE;
                     end else if (full) begin
                        res_status_in = STAT_FULL;
                     end else begin
                        cmd.op    = CELL_INSERT;
                        length_in = length_ff + LW'(1);
                     end
                  end
                  ACT_DELETE_AT: begin
                     if (del_range) begin
                        res_status_in = STAT_RANGE;
                     end else begin
                        cmd.op         = CELL_DELETE;
                        length_in      = length_ff - LW'(1);
                        res_removed_in = LW'(1);
                     end
                  end
                  default: begin
                     cmd.op = CELL_HOLD;
                  end
               endcase
            end
         end
         ST_ROT: begin
            cmd.op   = CELL_ROTATE;
            cmd.keep = !drop;
            cnt_in   = cnt_ff - LW'(1);
            if (drop) begin
               length_in      = length_ff - LW'(1);
               res_removed_in = res_removed_ff + LW'(1);
            end
            if (match) begin
               res_found_in = 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_found_in   = res_found_ff;
               rsp_removed_in = removed_w[10:0];
               rsp_length_in  = len_w[10:0];
               rsp_status_in  = res_status_ff;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff         <= cnt_in;
      val_ff         <= val_in;
      del_ff         <= del_in;
      res_found_ff   <= res_found_in;
      res_removed_ff <= res_removed_in;
      res_status_ff  <= res_status_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_length_ff  <= rsp_length_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_removed_count = rsp_removed_ff;
   assign rsp_length_now    = rsp_length_ff;
   assign rsp_status        = rsp_status_ff;

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      length_ff <= LW'(DEPTH))
      else $error("length exceeds depth");

   a_rot_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROT |-> cnt_ff != '0 && cnt_ff <= length_ff)
      else $error("rotation count out of step with length");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_action == ACT_INSERT && !ins_range && !full
      |=> length_ff == $past(length_ff) + LW'(1))
      else $error("insert did not grow length");

   a_idle_no_result_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && out_free |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("result not moved to output register");

endmodule

FILE: design/ordered_array_insert_delete_search.sv
// Positional array of DEPTH signed words kept in a chain of cells, one word per cell.
// Insert and delete-at shift the affected cells by one place all at once; a
// request of either kind, or any request that is rejected or finds the array empty,
// goes from the idle state through the done state to the output register.
// Delete-value and search rotate the whole array once through cell 0, where each word
// is compared, dropped or appended back at the tail: these go through the rotate state
// and the done state to the output register. A new request is taken once the previous
// result has moved to the output register, which holds it until transferred.
// Depends on oaids_pkg, oaids_cell and oaids_ctrl.
module ordered_array_insert_delete_search
   import oaids_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_action,
   input  logic [10:0]         req_position,
   input  logic signed [31:0]  req_item_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_found,
   output logic [10:0]         rsp_removed_count,
   output logic [10:0]         rsp_length_now,
   output logic [1:0]          rsp_status
);

   localparam int LW = $clog2(DEPTH + 1);

   cell_cmd_type  cmd;
   logic [LW-1:0] cell_pos;
   logic [LW-1:0] cell_len;
   logic [31:0]   slot [DEPTH];

   oaids_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_position      (req_position),
      .req_item_value    (req_item_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_removed_count (rsp_removed_count),
      .rsp_length_now    (rsp_length_now),
      .rsp_status        (rsp_status),
      .head              (slot[0]),
      .cmd               (cmd),
      .cell_pos          (cell_pos),
      .cell_len          (cell_len)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [31:0] left_data;
      logic [31:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_mid_l
         assign left_data = slot[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_mid_r
         assign right_data = slot[i+1];
      end

      oaids_cell #(
         .DEPTH(DEPTH),
         .IDX  (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .pos        (cell_pos),
         .len        (cell_len),
         .head       (slot[0]),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (slot[i])
      );
   end

endmodule
